### rtl/lkvc_pkg.sv
// ---------------------------------------------------------------------------
// lkvc_pkg
// shared codes, widths and control bundles of the lru key/value cache
// ---------------------------------------------------------------------------
package lkvc_pkg;

   localparam int OP_BITS  = 3;
   localparam int CAP_BITS = 5;
   localparam int OCC_BITS = 5;

   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   // request op codes
   localparam logic [OP_BITS-1:0] OP_GET    = 3'd0;
   localparam logic [OP_BITS-1:0] OP_SET    = 3'd1;
   localparam logic [OP_BITS-1:0] OP_HAS    = 3'd2;
   localparam logic [OP_BITS-1:0] OP_REMOVE = 3'd3;
   localparam logic [OP_BITS-1:0] OP_CLEAR  = 3'd4;

   // rank update rule applied during the update pass
   typedef enum logic [1:0] {
      AGE_PROMOTE = 2'd0,
      AGE_INSERT  = 2'd1,
      AGE_DROP    = 2'd2
   } age_mode_type;

   typedef struct packed {
      age_mode_type mode;
      logic         trim;
      logic         target;
      logic         valid;
   } age_ctl_type;

   typedef struct packed {
      logic keep;
      logic write;
   } age_res_type;

   typedef struct packed {
      logic key_en;
      logic value_en;
      logic age_en;
   } mem_wr_type;

endpackage

### rtl/lkvc_req_if.sv
// ---------------------------------------------------------------------------
// lkvc_req_if
// request channel: op, key and value with valid/ready
// ---------------------------------------------------------------------------
interface lkvc_req_if #(
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
);
   logic                         valid;
   logic                         ready;
   logic [lkvc_pkg::OP_BITS-1:0] op;
   logic [KEY_BITS-1:0]          key;
   logic [VALUE_BITS-1:0]        value;

   modport source (output valid, op, key, value, input ready);
   modport sink   (input valid, op, key, value, output ready);
endinterface

### rtl/lkvc_rsp_if.sv
// ---------------------------------------------------------------------------
// lkvc_rsp_if
// response channel: found, read value and occupancy with valid/ready
// ---------------------------------------------------------------------------
interface lkvc_rsp_if #(
   parameter int VALUE_BITS = 32
);
   logic                          valid;
   logic                          ready;
   logic                          found;
   logic [VALUE_BITS-1:0]         read_value;
   logic [lkvc_pkg::OCC_BITS-1:0] occupancy;

   modport source (output valid, found, read_value, occupancy, input ready);
   modport sink   (input valid, found, read_value, occupancy, output ready);
endinterface

### rtl/lkvc_csr_if.sv
// ---------------------------------------------------------------------------
// lkvc_csr_if
// capacity register write channel with valid/ready
// ---------------------------------------------------------------------------
interface lkvc_csr_if;
   logic                          valid;
   logic                          ready;
   logic [lkvc_pkg::CAP_BITS-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

### rtl/lkvc_entry_mem.sv
// ---------------------------------------------------------------------------
// lkvc_entry_mem
// key, value and rank storage, one registered read and one write per cycle
// ---------------------------------------------------------------------------
module lkvc_entry_mem #(
   parameter int DEPTH      = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32,
   parameter int IDX_BITS   = 4,
   parameter int AGE_BITS   = 4
) (
   input  logic                     clock,
   input  logic [IDX_BITS-1:0]      rd_addr,
   output logic [KEY_BITS-1:0]      rd_key,
   output logic [VALUE_BITS-1:0]    rd_value,
   output logic [AGE_BITS-1:0]      rd_age,
   input  lkvc_pkg::mem_wr_type     wr,
   input  logic [IDX_BITS-1:0]      wr_addr,
   input  logic [KEY_BITS-1:0]      wr_key,
   input  logic [VALUE_BITS-1:0]    wr_value,
   input  logic [AGE_BITS-1:0]      wr_age
);

   logic [KEY_BITS-1:0]   key_mem [DEPTH];
   logic [VALUE_BITS-1:0] val_mem [DEPTH];
   logic [AGE_BITS-1:0]   age_mem [DEPTH];

   logic [KEY_BITS-1:0]   key_rd_ff;
   logic [VALUE_BITS-1:0] val_rd_ff;
   logic [AGE_BITS-1:0]   age_rd_ff;

   always_ff @(posedge clock) begin
      if (wr.key_en) begin
         key_mem[wr_addr] <= wr_key;
      end
      if (wr.value_en) begin
         val_mem[wr_addr] <= wr_value;
      end
      if (wr.age_en) begin
         age_mem[wr_addr] <= wr_age;
      end
      key_rd_ff <= key_mem[rd_addr];
      val_rd_ff <= val_mem[rd_addr];
      age_rd_ff <= age_mem[rd_addr];
   end

   assign rd_key   = key_rd_ff;
   assign rd_value = val_rd_ff;
   assign rd_age   = age_rd_ff;

endmodule

### rtl/lkvc_age_unit.sv
// ---------------------------------------------------------------------------
// lkvc_age_unit
// shared rank update and capacity trim, applied to one entry per cycle
// ---------------------------------------------------------------------------
module lkvc_age_unit #(
   parameter int AGE_BITS = 4,
   parameter int CNT_BITS = 5
) (
   input  lkvc_pkg::age_ctl_type ctl,
   input  logic [AGE_BITS-1:0]   age_in,
   input  logic [AGE_BITS-1:0]   ref_age,
   input  logic [CNT_BITS-1:0]   cap_lim,
   output lkvc_pkg::age_res_type res,
   output logic [AGE_BITS-1:0]   age_out
);

   logic [AGE_BITS-1:0] age_next;
   logic                keep;

   always_comb begin
      age_next = age_in;
      keep     = ctl.valid;
      case (ctl.mode)
         lkvc_pkg::AGE_PROMOTE: begin
            if (ctl.target) begin
               age_next = '0;
            end else if (age_in < ref_age) begin
               age_next = age_in + 1'b1;
            end
         end
         lkvc_pkg::AGE_INSERT: begin
            if (ctl.target) begin
               age_next = '0;
               keep     = 1'b1;
            end else begin
               age_next = age_in + 1'b1;
            end
         end
         lkvc_pkg::AGE_DROP: begin
            if (ctl.target) begin
               keep = 1'b0;
            end else if (age_in > ref_age) begin
               age_next = age_in - 1'b1;
            end
         end
         default: begin
            age_next = age_in;
         end
      endcase
      // ranks at or past the capacity fall out
      if (ctl.trim && keep && (CNT_BITS'(age_next) >= cap_lim)) begin
         keep = 1'b0;
      end
      res.keep  = keep;
      res.write = keep;
      age_out   = age_next;
   end

endmodule

### rtl/lru_key_value_cache.sv
// ---------------------------------------------------------------------------
// lru_key_value_cache
// fully associative key/value store with least-recently-used replacement
// ---------------------------------------------------------------------------
//  channel  | dir | handshake    | payload
//  req_ch   | in  | valid/ready  | op, key, value
//  rsp_ch   | out | valid/ready  | found, read_value, occupancy
//  csr_ch   | in  | valid/ready  | data (capacity, saturated to DEPTH)
//
//  a request walks the entry memory through its single read port: a lookup
//  pass, a plan state, then an update pass for get hit, set and remove hit
//  only, then the response state; other requests skip the update pass, and
//  unknown ops skip the lookup and go straight to the response state
//  req_ch.ready is high only while idle; a waiting response does not block it
//  synchronous active-high reset empties the store, capacity resets to 16
// ---------------------------------------------------------------------------
module lru_key_value_cache #(
   parameter int DEPTH      = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input logic       clock,
   input logic       reset,
   lkvc_req_if.sink  req_ch,
   lkvc_rsp_if.source rsp_ch,
   lkvc_csr_if.sink  csr_ch
);

   localparam int AGE_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IDX_BITS = AGE_BITS;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam int CMP_BITS = (CNT_BITS > lkvc_pkg::CAP_BITS) ? CNT_BITS : lkvc_pkg::CAP_BITS;
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

   // sequencer states
   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SCAN   = 5'b00010,
      S_PLAN   = 5'b00100,
      S_UPDATE = 5'b01000,
      S_RESP   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // latched request
   logic [lkvc_pkg::OP_BITS-1:0] op_ff, op_in;
   logic [KEY_BITS-1:0]          key_ff, key_in;
   logic [VALUE_BITS-1:0]        value_ff, value_in;

   // pass address issue and read-data pipeline tag
   logic                issue_on_ff, issue_on_in;
   logic [IDX_BITS-1:0] issue_idx_ff, issue_idx_in;
   logic                pipe_vld_ff, pipe_vld_in;
   logic [IDX_BITS-1:0] pipe_idx_ff, pipe_idx_in;

   // lookup pass results
   logic                  hit_ff, hit_in;
   logic [IDX_BITS-1:0]   hit_idx_ff, hit_idx_in;
   logic [AGE_BITS-1:0]   hit_age_ff, hit_age_in;
   logic [VALUE_BITS-1:0] hit_val_ff, hit_val_in;
   logic                  free_ff, free_in;
   logic [IDX_BITS-1:0]   free_idx_ff, free_idx_in;
   logic [IDX_BITS-1:0]   old_idx_ff, old_idx_in;

   // entry state kept in flops
   logic [DEPTH-1:0]    valid_ff, valid_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [CNT_BITS-1:0] cnt_acc_ff, cnt_acc_in;
   logic [lkvc_pkg::CAP_BITS-1:0] capacity_ff, capacity_in;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_found_ff, rsp_found_in;
   logic [VALUE_BITS-1:0]         rsp_value_ff, rsp_value_in;
   logic [lkvc_pkg::OCC_BITS-1:0] rsp_occ_ff, rsp_occ_in;

   // memory and rank unit hookup
   logic [KEY_BITS-1:0]   rd_key;
   logic [VALUE_BITS-1:0] rd_value;
   logic [AGE_BITS-1:0]   rd_age;
   lkvc_pkg::mem_wr_type  mem_wr;
   lkvc_pkg::age_ctl_type age_ctl;
   lkvc_pkg::age_res_type age_res;
   logic [AGE_BITS-1:0]   age_new;

   // decode helpers
   logic                   req_fire;
   logic                   pipe_valid_bit;
   logic                   key_match;
   logic                   pass_last;
   logic                   needs_update;
   logic [IDX_BITS-1:0]    tgt_idx;
   logic [AGE_BITS-1:0]    oldest_age;
   logic [CNT_BITS-1:0]    cap_lim;
   logic [CMP_BITS-1:0]    cap_ext;
   logic [CNT_BITS-1:0]    cnt_sum;
   lkvc_pkg::age_mode_type upd_mode;

   assign req_fire       = req_ch.valid && req_ch.ready;
   assign req_ch.ready   = (state_ff == S_IDLE);
   assign csr_ch.ready   = 1'b1;
   assign pipe_valid_bit = valid_ff[pipe_idx_ff];
   assign key_match      = pipe_valid_bit && (rd_key == key_ff);
   assign pass_last      = pipe_vld_ff && (pipe_idx_ff == LAST_IDX);
   assign oldest_age     = AGE_BITS'(count_ff - 1'b1);

   // capacity above the store depth behaves as the depth
   assign cap_ext = (CMP_BITS'(capacity_ff) > CMP_BITS'(DEPTH)) ? CMP_BITS'(DEPTH)
                                                                : CMP_BITS'(capacity_ff);
   assign cap_lim = CNT_BITS'(cap_ext);

   // remove drops the hit, get and set promote it, a set miss inserts
   assign upd_mode = hit_ff ? ((op_ff == lkvc_pkg::OP_REMOVE) ? lkvc_pkg::AGE_DROP
                                                              : lkvc_pkg::AGE_PROMOTE)
                            : lkvc_pkg::AGE_INSERT;
   assign needs_update = (op_ff == lkvc_pkg::OP_SET) ||
                         (hit_ff && ((op_ff == lkvc_pkg::OP_GET) ||
                                     (op_ff == lkvc_pkg::OP_REMOVE)));

   // insert into a full store reuses the oldest slot, otherwise the first free one
   assign tgt_idx = hit_ff ? hit_idx_ff : ((count_ff == FULL_CNT) ? old_idx_ff : free_idx_ff);

   assign age_ctl.mode   = upd_mode;
   assign age_ctl.trim   = (op_ff == lkvc_pkg::OP_SET);
   assign age_ctl.target = (pipe_idx_ff == tgt_idx);
   assign age_ctl.valid  = pipe_valid_bit;

   assign cnt_sum = cnt_acc_ff + CNT_BITS'(age_res.keep);

   lkvc_entry_mem #(
      .DEPTH      (DEPTH),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .IDX_BITS   (IDX_BITS),
      .AGE_BITS   (AGE_BITS)
   ) u_mem (
      .clock    (clock),
      .rd_addr  (issue_idx_ff),
      .rd_key   (rd_key),
      .rd_value (rd_value),
      .rd_age   (rd_age),
      .wr       (mem_wr),
      .wr_addr  (pipe_idx_ff),
      .wr_key   (key_ff),
      .wr_value (value_ff),
      .wr_age   (age_new)
   );

   lkvc_age_unit #(
      .AGE_BITS (AGE_BITS),
      .CNT_BITS (CNT_BITS)
   ) u_age (
      .ctl     (age_ctl),
      .age_in  (rd_age),
      .ref_age (hit_age_ff),
      .cap_lim (cap_lim),
      .res     (age_res),
      .age_out (age_new)
   );

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      issue_on_in  = issue_on_ff;
      issue_idx_in = issue_idx_ff;
      pipe_vld_in  = 1'b0;
      pipe_idx_in  = pipe_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_age_in   = hit_age_ff;
      hit_val_in   = hit_val_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      old_idx_in   = old_idx_ff;
      valid_in     = valid_ff;
      count_in     = count_ff;
      cnt_acc_in   = cnt_acc_ff;
      capacity_in  = capacity_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_found_in = rsp_found_ff;
      rsp_value_in = rsp_value_ff;
      rsp_occ_in   = rsp_occ_ff;
      mem_wr       = '0;

      if (csr_ch.valid) begin
         capacity_in = csr_ch.data;
      end

      // one read address per cycle, data tagged in the cycle after
      if (issue_on_ff) begin
         pipe_vld_in = 1'b1;
         pipe_idx_in = issue_idx_ff;
         if (issue_idx_ff == LAST_IDX) begin
            issue_on_in = 1'b0;
         end else begin
            issue_idx_in = issue_idx_ff + 1'b1;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in        = req_ch.op;
               key_in       = req_ch.key;
               value_in     = req_ch.value;
               hit_in       = 1'b0;
               free_in      = 1'b0;
               issue_idx_in = '0;
               // unknown ops go straight to the response state with no lookup
               if (req_ch.op inside {[lkvc_pkg::OP_GET:lkvc_pkg::OP_CLEAR]}) begin
                  issue_on_in = 1'b1;
                  state_in    = S_SCAN;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_SCAN: begin
            if (pipe_vld_ff) begin
               if (key_match && !hit_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = pipe_idx_ff;
                  hit_age_in = rd_age;
                  hit_val_in = rd_value;
               end
               if (!pipe_valid_bit && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = pipe_idx_ff;
               end
               if (pipe_valid_bit && (rd_age == oldest_age)) begin
                  old_idx_in = pipe_idx_ff;
               end
               if (pass_last) begin
                  state_in = S_PLAN;
               end
            end
         end
         S_PLAN: begin
            if (op_ff == lkvc_pkg::OP_CLEAR) begin
               valid_in = '0;
               count_in = '0;
               state_in = S_RESP;
            end else if (needs_update) begin
               issue_on_in  = 1'b1;
               issue_idx_in = '0;
               cnt_acc_in   = '0;
               state_in     = S_UPDATE;
            end else begin
               state_in = S_RESP;
            end
         end
         S_UPDATE: begin
            if (pipe_vld_ff) begin
               valid_in[pipe_idx_ff] = age_res.keep;
               mem_wr.age_en   = age_res.write;
               mem_wr.key_en   = (upd_mode == lkvc_pkg::AGE_INSERT) && age_ctl.target;
               mem_wr.value_en = (op_ff == lkvc_pkg::OP_SET) && age_ctl.target;
               cnt_acc_in      = cnt_sum;
               if (pass_last) begin
                  count_in = cnt_sum;
                  state_in = S_RESP;
               end
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = hit_ff;
               rsp_value_in = ((op_ff == lkvc_pkg::OP_GET) && hit_ff) ? hit_val_ff : '0;
               rsp_occ_in   = lkvc_pkg::OCC_BITS'(count_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issue_on_ff  <= 1'b0;
         pipe_vld_ff  <= 1'b0;
         valid_ff     <= '0;
         count_ff     <= '0;
         capacity_ff  <= lkvc_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_on_ff  <= issue_on_in;
         pipe_vld_ff  <= pipe_vld_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      value_ff     <= value_in;
      issue_idx_ff <= issue_idx_in;
      pipe_idx_ff  <= pipe_idx_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      hit_age_ff   <= hit_age_in;
      hit_val_ff   <= hit_val_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      old_idx_ff   <= old_idx_in;
      cnt_acc_ff   <= cnt_acc_in;
      rsp_found_ff <= rsp_found_in;
      rsp_value_ff <= rsp_value_in;
      rsp_occ_ff   <= rsp_occ_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.found      = rsp_found_ff;
   assign rsp_ch.read_value = rsp_value_ff;
   assign rsp_ch.occupancy  = rsp_occ_ff;

`ifndef SYNTHESIS
   // one request in flight: ready drops right after an accepted request
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ch.ready)
      else $error("request accepted while a request is in flight");

   // a new response only comes out of the response state
   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP))
      else $error("response raised outside the response state");

   // occupancy tracks the valid bits whenever the block is idle
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (int'(count_ff) == $countones(valid_ff)))
      else $error("entry count disagrees with valid bits");

   // a set always leaves the store within capacity
   a_set_trimmed: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_RESP) && (op_ff == lkvc_pkg::OP_SET)) |-> (count_ff <= cap_lim))
      else $error("set left more entries than capacity");
`endif

endmodule
